// ===== design/kpsd_pkg.sv =====
// Shared types, constants and key decode functions for the keypad scanner.
package kpsd_pkg;

  localparam int ROW_COUNT   = 4;
  localparam int ROW_W       = $clog2(ROW_COUNT);
  localparam int COL_W       = 4;
  localparam int SEG_W       = 8;
  localparam int TICK_W      = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BEEP     = 2'd1;

  localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [TICK_W-1:0] BEEP_RESET     = 16'd5;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
  localparam logic [SEG_W-1:0] SEG_C     = 8'hA7;
  localparam logic [SEG_W-1:0] SEG_T     = 8'h87;

  localparam logic [COL_W-1:0] COLS_IDLE = 4'hF;
  localparam logic [COL_W-1:0] COLS_KEY_C = 4'hE;

  typedef enum logic [4:0] {
    PH_SCAN     = 5'b00001,
    PH_DEBOUNCE = 5'b00010,
    PH_RELEASE  = 5'b00100,
    PH_BEEP     = 5'b01000,
    PH_COMBO    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } col_hit_t;

  function automatic col_hit_t column_index(input logic [COL_W-1:0] cols);
    col_hit_t r;
    r.hit = 1'b1;
    r.idx = 2'd0;
    case (cols)
      4'h7: r.idx = 2'd0;
      4'hB: r.idx = 2'd1;
      4'hD: r.idx = 2'd2;
      4'hE: r.idx = 2'd3;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [SEG_W-1:0] key_seg(input logic [ROW_W-1:0] row,
                                               input logic [1:0] col);
    logic [SEG_W-1:0] s;
    case ({row, col})
      4'h0: s = 8'hF9;
      4'h1: s = 8'h92;
      4'h2: s = 8'h98;
      4'h3: s = 8'hA7;
      4'h4: s = 8'hA4;
      4'h5: s = 8'h82;
      4'h6: s = 8'hC0;
      4'h7: s = 8'hA1;
      4'h8: s = 8'hB0;
      4'h9: s = 8'hF8;
      4'hA: s = 8'hA0;
      4'hB: s = 8'h86;
      4'hC: s = 8'h99;
      4'hD: s = 8'h80;
      4'hE: s = 8'h83;
      default: s = 8'h8E;
    endcase
    return s;
  endfunction

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

// ===== design/keypad_scan_debounce_display_core.sv =====
// Keypad scanner top level: scan, debounce, combo watch, segment latch and buzzer.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   input    | in_valid / in_stall        | column_lines
//   output   | out_valid / out_stall      | row_drive, segments, buzzer_on
//   config   | cfg_we                     | cfg_index, cfg_data
//
// One request per cycle while in_stall is low; its result is registered.
// The scan state updates in the same cycle a request is accepted.
// A two-entry output buffer (result register plus skid) keeps input acceptance going
// while the output is stalled; in_stall rises only when both entries are full.
// Sync reset empties both buffer entries, clears the scan state, loads config defaults.
module keypad_scan_debounce_display_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [kpsd_pkg::COL_W-1:0]           column_lines,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [kpsd_pkg::ROW_COUNT-1:0]       row_drive,
  output logic [kpsd_pkg::SEG_W-1:0]           segments,
  output logic                                 buzzer_on,
  input  logic                                 cfg_we,
  input  logic [kpsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [kpsd_pkg::TICK_W-1:0]          cfg_data
);

  logic [kpsd_pkg::TICK_W-1:0]    debounce_ticks;
  logic [kpsd_pkg::TICK_W-1:0]    beep_ticks;

  logic [kpsd_pkg::ROW_W-1:0]     current_row, current_row_next;
  kpsd_pkg::phase_t               phase, phase_next;
  logic [kpsd_pkg::TICK_W-1:0]    wait_count, wait_count_next;
  logic [kpsd_pkg::COL_W-1:0]     held_column, held_column_next;
  logic [kpsd_pkg::SEG_W-1:0]     shown_pattern, shown_pattern_next;
  logic                           combo_seen, combo_seen_next;
  logic                           buzz_next;

  logic                           skid_valid;
  logic [kpsd_pkg::ROW_COUNT-1:0] skid_row;
  logic [kpsd_pkg::SEG_W-1:0]     skid_seg;
  logic                           skid_buzz;

  logic                           accept;
  logic                           out_free;
  logic [kpsd_pkg::ROW_COUNT-1:0] row_drive_next;
  kpsd_pkg::col_hit_t             scan_hit;
  kpsd_pkg::col_hit_t             held_hit;

  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = skid_valid;

  assign scan_hit = kpsd_pkg::column_index(column_lines);
  assign held_hit = kpsd_pkg::column_index(held_column);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= kpsd_pkg::DEBOUNCE_RESET;
      beep_ticks     <= kpsd_pkg::BEEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpsd_pkg::REG_DEBOUNCE: debounce_ticks <= cfg_data;
        kpsd_pkg::REG_BEEP:     beep_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    current_row_next   = current_row;
    phase_next         = phase;
    wait_count_next    = wait_count;
    held_column_next   = held_column;
    shown_pattern_next = shown_pattern;
    combo_seen_next    = combo_seen;
    buzz_next          = 1'b0;
    unique case (phase)
      kpsd_pkg::PH_DEBOUNCE: begin
        if (wait_count > kpsd_pkg::TICK_W'(1)) begin
          wait_count_next = wait_count - kpsd_pkg::TICK_W'(1);
        end else if (column_lines == held_column) begin
          if (current_row == '0 && column_lines == kpsd_pkg::COLS_KEY_C) begin
            shown_pattern_next = kpsd_pkg::SEG_C;
            combo_seen_next    = 1'b0;
            phase_next         = kpsd_pkg::PH_COMBO;
            current_row_next   = kpsd_pkg::ROW_W'(1);
          end else begin
            phase_next = kpsd_pkg::PH_RELEASE;
          end
        end else begin
          phase_next       = kpsd_pkg::PH_SCAN;
          current_row_next = current_row + kpsd_pkg::ROW_W'(1);
        end
      end
      kpsd_pkg::PH_RELEASE: begin
        if (column_lines != held_column) begin
          shown_pattern_next = held_hit.hit ? kpsd_pkg::key_seg(current_row, held_hit.idx)
                                            : kpsd_pkg::SEG_BLANK;
          wait_count_next    = kpsd_pkg::at_least_one(beep_ticks);
          phase_next         = kpsd_pkg::PH_BEEP;
          buzz_next          = 1'b1;
        end
      end
      kpsd_pkg::PH_BEEP: begin
        if (wait_count > kpsd_pkg::TICK_W'(1)) begin
          wait_count_next = wait_count - kpsd_pkg::TICK_W'(1);
          buzz_next       = 1'b1;
        end else begin
          wait_count_next  = '0;
          phase_next       = kpsd_pkg::PH_SCAN;
          current_row_next = current_row + kpsd_pkg::ROW_W'(1);
        end
      end
      kpsd_pkg::PH_COMBO: begin
        if (current_row == kpsd_pkg::ROW_W'(1)) begin
          if (!column_lines[3]) begin
            combo_seen_next    = 1'b1;
            shown_pattern_next = kpsd_pkg::SEG_T;
          end
          current_row_next = '0;
        end else if (column_lines[0]) begin
          if (combo_seen) begin
            shown_pattern_next = kpsd_pkg::SEG_T;
            combo_seen_next    = 1'b0;
            phase_next         = kpsd_pkg::PH_SCAN;
            current_row_next   = kpsd_pkg::ROW_W'(1);
          end else begin
            current_row_next   = '0;
            shown_pattern_next = kpsd_pkg::SEG_C;
            wait_count_next    = kpsd_pkg::at_least_one(beep_ticks);
            phase_next         = kpsd_pkg::PH_BEEP;
            buzz_next          = 1'b1;
          end
        end else begin
          current_row_next = kpsd_pkg::ROW_W'(1);
        end
      end
      default: begin
        if (scan_hit.hit) begin
          held_column_next = column_lines;
          wait_count_next  = kpsd_pkg::at_least_one(debounce_ticks);
          phase_next       = kpsd_pkg::PH_DEBOUNCE;
        end else begin
          phase_next       = kpsd_pkg::PH_SCAN;
          current_row_next = current_row + kpsd_pkg::ROW_W'(1);
        end
      end
    endcase
    row_drive_next = ~(kpsd_pkg::ROW_COUNT'(1) << current_row_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row   <= '0;
      phase         <= kpsd_pkg::PH_SCAN;
      wait_count    <= '0;
      held_column   <= kpsd_pkg::COLS_IDLE;
      shown_pattern <= kpsd_pkg::SEG_BLANK;
      combo_seen    <= 1'b0;
    end else if (accept) begin
      current_row   <= current_row_next;
      phase         <= phase_next;
      wait_count    <= wait_count_next;
      held_column   <= held_column_next;
      shown_pattern <= shown_pattern_next;
      combo_seen    <= combo_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= skid_valid || accept;
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        row_drive <= skid_row;
        segments  <= skid_seg;
        buzzer_on <= skid_buzz;
      end else if (accept) begin
        row_drive <= row_drive_next;
        segments  <= shown_pattern_next;
        buzzer_on <= buzz_next;
      end
    end else if (accept) begin
      skid_row  <= row_drive_next;
      skid_seg  <= shown_pattern_next;
      skid_buzz <= buzz_next;
    end
  end

endmodule

// ===== design/kpsd_checker.sv =====
// Port-level checks for the keypad scanner and their binding to the top level.
module kpsd_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [kpsd_pkg::ROW_COUNT-1:0]       row_drive,
  input logic [kpsd_pkg::SEG_W-1:0]           segments,
  input logic                                 buzzer_on
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(row_drive) && $stable(segments)
                               && $stable(buzzer_on))
    else $error("stalled result changed");

  a_one_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(~row_drive))
    else $error("row drive selects other than one row");

  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_stall |=> out_valid && !in_stall)
    else $error("buffered result not moved forward");

endmodule

bind keypad_scan_debounce_display_core kpsd_checker u_kpsd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .row_drive (row_drive),
  .segments  (segments),
  .buzzer_on (buzzer_on)
);

// ===== tb/sv/testbench.sv =====
// Testbench for the keypad scanner core: table-driven directed ticks, then random key traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] row_drive;
    logic [7:0] segments;
    logic       buzzer_on;
  } scan_out_t;

  typedef enum logic {STEP_TICK, STEP_REGS} step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    logic [3:0]  cols;
    logic [15:0] deb;
    logic [15:0] beep;
    logic        typed;
    scan_out_t   want;
  } plan_row_t;

  localparam logic [kpsd_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [kpsd_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int PHASE_ITEMS = 165;
  localparam int PHASES = 5;
  localparam logic [15:0] DEB_SET [PHASES] = '{16'd1, 16'd2, 16'd5, 16'd1, 16'd3};
  localparam logic [15:0] BEEP_SET [PHASES] = '{16'd1, 16'd3, 16'd2, 16'd6, 16'd1};

  localparam logic [3:0] ONE_LOW [4] = '{4'h7, 4'hB, 4'hD, 4'hE};
  localparam logic [7:0] KEY_GLYPH [4][4] = '{
    '{8'hF9, 8'h92, 8'h98, 8'hA7},
    '{8'hA4, 8'h82, 8'hC0, 8'hA1},
    '{8'hB0, 8'hF8, 8'hA0, 8'h86},
    '{8'h99, 8'h80, 8'h83, 8'h8E}
  };

  localparam int PLAN_LEN = 26;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{STEP_TICK, 4'hF, 16'd0, 16'd0, 1'b1, '{4'hD, kpsd_pkg::SEG_BLANK, 1'b0}},
    '{STEP_TICK, 4'h0, 16'd0, 16'd0, 1'b1, '{4'hB, kpsd_pkg::SEG_BLANK, 1'b0}},
    '{STEP_REGS, 4'hF, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hE, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hE, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'h0, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hF, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hD, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'h7, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hE, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hE, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'h7, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hE, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hF, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hF, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hF, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hF, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hE, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hE, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hF, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hF, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hE, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hE, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hF, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'h1, 16'd0, 16'd0, 1'b0, '0},
    '{STEP_TICK, 4'hF, 16'd0, 16'd0, 1'b0, '0}
  };

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [kpsd_pkg::COL_W-1:0]       column_lines = kpsd_pkg::COLS_IDLE;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [kpsd_pkg::ROW_COUNT-1:0]   row_drive;
  logic [kpsd_pkg::SEG_W-1:0]       segments;
  logic                             buzzer_on;
  logic                             cfg_we = 1'b0;
  logic [kpsd_pkg::CFG_INDEX_W-1:0] cfg_index = kpsd_pkg::REG_DEBOUNCE;
  logic [kpsd_pkg::TICK_W-1:0]      cfg_data = '0;

  logic [15:0]      deb_ticks = kpsd_pkg::DEBOUNCE_RESET;
  logic [15:0]      beep_ticks = kpsd_pkg::BEEP_RESET;
  logic [1:0]       k_row = 2'd0;
  kpsd_pkg::phase_t k_phase = kpsd_pkg::PH_SCAN;
  logic [15:0]      k_wait = 16'd0;
  logic [3:0]       k_held = kpsd_pkg::COLS_IDLE;
  logic [7:0]       k_shown = kpsd_pkg::SEG_BLANK;
  logic             k_combo = 1'b0;

  scan_out_t display_due [$];
  scan_out_t front;
  int        bad_fields = 0;
  int        stall_left = 0;

  keypad_scan_debounce_display_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .column_lines (column_lines),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .row_drive    (row_drive),
    .segments     (segments),
    .buzzer_on    (buzzer_on),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int col_pos(input logic [3:0] cols);
    case (cols)
      4'h7: return 0;
      4'hB: return 1;
      4'hD: return 2;
      4'hE: return 3;
      default: return -1;
    endcase
  endfunction

  function automatic logic [15:0] nonzero_ticks(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic void sound_key(input logic [7:0] glyph);
    k_shown = glyph;
    k_wait = nonzero_ticks(beep_ticks);
    k_phase = kpsd_pkg::PH_BEEP;
  endfunction

  function automatic scan_out_t scan_tick(input logic [3:0] cols);
    scan_out_t r;
    logic buzz;
    buzz = 1'b0;
    case (k_phase)
      kpsd_pkg::PH_DEBOUNCE: begin
        if (k_wait > 16'd1) begin
          k_wait = k_wait - 16'd1;
        end else if (cols == k_held) begin
          if (k_row == 2'd0 && cols == kpsd_pkg::COLS_KEY_C) begin
            k_shown = kpsd_pkg::SEG_C;
            k_combo = 1'b0;
            k_phase = kpsd_pkg::PH_COMBO;
            k_row = 2'd1;
          end else begin
            k_phase = kpsd_pkg::PH_RELEASE;
          end
        end else begin
          k_phase = kpsd_pkg::PH_SCAN;
          k_row = k_row + 2'd1;
        end
      end
      kpsd_pkg::PH_RELEASE: begin
        if (cols != k_held) begin
          sound_key(KEY_GLYPH[k_row][col_pos(k_held)]);
          buzz = 1'b1;
        end
      end
      kpsd_pkg::PH_BEEP: begin
        if (k_wait > 16'd1) begin
          k_wait = k_wait - 16'd1;
          buzz = 1'b1;
        end else begin
          k_wait = 16'd0;
          k_phase = kpsd_pkg::PH_SCAN;
          k_row = k_row + 2'd1;
        end
      end
      kpsd_pkg::PH_COMBO: begin
        if (k_row == 2'd1) begin
          if (!cols[3]) begin
            k_combo = 1'b1;
            k_shown = kpsd_pkg::SEG_T;
          end
          k_row = 2'd0;
        end else if (cols[0]) begin
          if (k_combo) begin
            k_shown = kpsd_pkg::SEG_T;
            k_combo = 1'b0;
            k_phase = kpsd_pkg::PH_SCAN;
            k_row = 2'd1;
          end else begin
            k_row = 2'd0;
            sound_key(kpsd_pkg::SEG_C);
            buzz = 1'b1;
          end
        end else begin
          k_row = 2'd1;
        end
      end
      default: begin
        k_phase = kpsd_pkg::PH_SCAN;
        if (col_pos(cols) >= 0) begin
          k_held = cols;
          k_wait = nonzero_ticks(deb_ticks);
          k_phase = kpsd_pkg::PH_DEBOUNCE;
        end else begin
          k_row = k_row + 2'd1;
        end
      end
    endcase
    r.row_drive = ~(4'b0001 << k_row);
    r.segments = k_shown;
    r.buzzer_on = buzz;
    return r;
  endfunction

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [3:0] pick_cols();
    logic [3:0] r;
    r = 4'($urandom);
    case (k_phase)
      kpsd_pkg::PH_DEBOUNCE: if ($urandom_range(0, 9) != 0) r = k_held;
      kpsd_pkg::PH_RELEASE: begin
        if ($urandom_range(0, 2) != 0) r = k_held;
        else if ($urandom_range(0, 1) == 0) r = kpsd_pkg::COLS_IDLE;
      end
      kpsd_pkg::PH_COMBO: begin
        if (k_row == 2'd1) r[3] = ($urandom_range(0, 2) != 0);
        else r[0] = ($urandom_range(0, 2) == 0);
      end
      kpsd_pkg::PH_BEEP: ;
      default: begin
        if ($urandom_range(0, 9) < 7) r = ONE_LOW[$urandom_range(0, 3)];
        if (k_row == 2'd0 && $urandom_range(0, 3) == 0) r = kpsd_pkg::COLS_KEY_C;
      end
    endcase
    return r;
  endfunction

  task automatic send_tick(input logic [3:0] cols, input logic typed, input scan_out_t want);
    int span;
    scan_out_t pred;
    span = idle_span();
    if (span > 0) begin
      in_valid <= 1'b0;
      repeat (span) @(posedge clk);
    end
    in_valid <= 1'b1;
    column_lines <= cols;
    do @(posedge clk); while (in_stall);
    pred = scan_tick(cols);
    display_due.push_back(typed ? want : pred);
  endtask

  task automatic program_regs(input logic [15:0] deb, input logic [15:0] beep);
    in_valid <= 1'b0;
    while (display_due.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= kpsd_pkg::REG_DEBOUNCE;
    cfg_data <= deb;
    @(posedge clk);
    deb_ticks = deb;
    cfg_index <= kpsd_pkg::REG_BEEP;
    cfg_data <= beep;
    @(posedge clk);
    beep_ticks = beep;
    cfg_index <= ($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B;
    cfg_data <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = idle_span();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (display_due.size() == 0) begin
        $error("result with nothing pending: row_drive %h segments %h buzzer_on %b",
               row_drive, segments, buzzer_on);
        bad_fields++;
      end else begin
        front = display_due.pop_front();
        if (row_drive !== front.row_drive) begin
          $error("row_drive: expected %h, got %h", front.row_drive, row_drive);
          bad_fields++;
        end
        if (segments !== front.segments) begin
          $error("segments: expected %h, got %h", front.segments, segments);
          bad_fields++;
        end
        if (buzzer_on !== front.buzzer_on) begin
          $error("buzzer_on: expected %b, got %b", front.buzzer_on, buzzer_on);
          bad_fields++;
        end
      end
    end
  end

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == STEP_REGS) program_regs(PLAN[i].deb, PLAN[i].beep);
      else send_tick(PLAN[i].cols, PLAN[i].typed, PLAN[i].want);
    end
    for (int p = 0; p < PHASES; p++) begin
      program_regs(DEB_SET[p], BEEP_SET[p]);
      n = 0;
      while (n < PHASE_ITEMS) begin
        n++;
        send_tick(pick_cols(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    while (display_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (bad_fields == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #16000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/kpsd_pkg.sv
design/keypad_scan_debounce_display_core.sv
design/kpsd_checker.sv
tb/sv/testbench.sv
